@@ design/modbus_position_reply_checker_unit_defines.svh @@
// assertion macros used by the checker file mprc_checker.sv
`ifndef MODBUS_POSITION_REPLY_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_POSITION_REPLY_CHECKER_UNIT_DEFINES_SVH

// checked only outside reset
`define MPRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MPRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mprc_pkg.sv @@
`default_nettype none
package mprc_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;
  localparam int TOL_W  = 24;
  localparam int CRC_W  = 16;
  localparam int IDX_W  = 5;
  localparam int AXES   = 3;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [BYTE_W-1:0]       byte_t;
  typedef logic [CRC_W-1:0]        crc_t;
  typedef logic [TOL_W-1:0]        tol_t;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam idx_t IDX_COORD_LO = 5'd3;
  localparam idx_t IDX_COORD_HI = 5'd14;
  localparam idx_t IDX_CRC_LO   = 5'd15;
  localparam idx_t IDX_LAST     = 5'd16;

  localparam crc_t CRC_INIT  = 16'hFFFF;
  localparam crc_t CRC_POLY  = 16'hA001;
  localparam tol_t TOL_RESET = 24'd1000;

  typedef struct packed {
    logic good;
    pos_t cur_x;
    pos_t cur_y;
    pos_t cur_z;
    pos_t got_x;
    pos_t got_y;
    pos_t got_z;
  } fin_t;

  // one byte of the reflected modbus crc, bit steps unrolled
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/mprc_if.sv @@
`default_nettype none
interface mprc_in_if;
  logic           valid;
  logic           ready;
  mprc_pkg::byte_t rx_byte;
  mprc_pkg::pos_t  cur_x;
  mprc_pkg::pos_t  cur_y;
  mprc_pkg::pos_t  cur_z;
  modport source (output valid, output rx_byte, output cur_x, output cur_y, output cur_z,
                  input ready);
  modport sink (input valid, input rx_byte, input cur_x, input cur_y, input cur_z,
                output ready);
endinterface

interface mprc_out_if;
  logic valid;
  logic ready;
  logic crc_good;
  logic near;
  modport source (output valid, output crc_good, output near, input ready);
  modport sink (input valid, input crc_good, input near, output ready);
endinterface

interface mprc_cfg_if;
  logic           valid;
  logic           ready;
  mprc_pkg::tol_t tolerance;
  modport source (output valid, output tolerance, input ready);
  modport sink (input valid, input tolerance, output ready);
endinterface
`default_nettype wire

@@ design/modbus_position_reply_checker_unit.sv @@
`default_nettype none
// channel   dir  handshake     payload
// in_req    in   valid/ready   rx_byte, cur_x, cur_y, cur_z
// out_res   out  valid/ready   crc_good, near
// cfg_wr    in   valid/ready   tolerance
//
// one request per cycle while in_req.ready is high; the result is registered
// crc byte update and coordinate shift happen on the accepted cycle,
// the 33-bit distance compares sit between the final stage and result register
// rst_n synchronous: frame counter and stage valids cleared, crc FFFF, tolerance 1000
// output stall fills the final stage, then in_req.ready drops
module modbus_position_reply_checker_unit (
  input wire logic     clk,
  input wire logic     rst_n,
  mprc_in_if.sink      in_req,
  mprc_out_if.source   out_res,
  mprc_cfg_if.sink     cfg_wr
);
  import mprc_pkg::*;

  tol_t tol_r;
  logic acc;
  logic fin_valid;
  fin_t fin;
  logic s1_ready;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr.valid) begin
      tol_r <= cfg_wr.tolerance;
    end
  end

  assign in_req.ready = s1_ready;
  assign acc          = in_req.valid && s1_ready;

  mprc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_req.rx_byte),
    .cur_x     (in_req.cur_x),
    .cur_y     (in_req.cur_y),
    .cur_z     (in_req.cur_z),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  mprc_near u_near (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin       (fin),
    .tol       (tol_r),
    .out_ready (out_res.ready),
    .s1_ready  (s1_ready),
    .out_valid (out_res.valid),
    .crc_good  (out_res.crc_good),
    .near      (out_res.near)
  );

endmodule
`default_nettype wire

@@ design/mprc_frame.sv @@
`default_nettype none
module mprc_frame (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire mprc_pkg::byte_t rx_byte,
  input  wire mprc_pkg::pos_t  cur_x,
  input  wire mprc_pkg::pos_t  cur_y,
  input  wire mprc_pkg::pos_t  cur_z,
  output logic                fin_valid,
  output mprc_pkg::fin_t      fin
);
  import mprc_pkg::*;

  idx_t  idx_r, idx_nxt, idx;
  crc_t  crc_r, crc_nxt;
  byte_t crc_lo_r, crc_lo_nxt;
  pos_t  coord_r [AXES];
  pos_t  coord_nxt [AXES];
  idx_t  coord_off;
  logic [1:0] sel;
  logic  last;
  logic  in_coord;

  always_comb begin
    idx       = (idx_r > IDX_LAST) ? '0 : idx_r;
    last      = (idx == IDX_LAST);
    idx_nxt   = last ? '0 : idx + 5'd1;
    coord_off = idx - IDX_COORD_LO;
    sel       = coord_off[3:2];
    in_coord  = (idx >= IDX_COORD_LO) && (idx <= IDX_COORD_HI);

    crc_nxt = crc_r;
    if (idx < IDX_CRC_LO) begin
      crc_nxt = crc_byte(crc_r, rx_byte);
    end
    if (last) begin
      crc_nxt = CRC_INIT;
    end

    crc_lo_nxt = (idx == IDX_CRC_LO) ? rx_byte : crc_lo_r;

    for (int a = 0; a < AXES; a++) begin
      coord_nxt[a] = coord_r[a];
      if (in_coord && (sel == 2'(a))) begin
        coord_nxt[a] = {coord_r[a][POS_W-BYTE_W-1:0], rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end else if (acc) begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
    end
  end

  // coordinates are fully shifted in before use
  always_ff @(posedge clk) begin
    if (acc) begin
      crc_lo_r <= crc_lo_nxt;
      for (int a = 0; a < AXES; a++) begin
        coord_r[a] <= coord_nxt[a];
      end
    end
  end

  assign fin_valid = acc && last;

  always_comb begin
    fin.good  = (crc_lo_r == crc_r[7:0]) && (rx_byte == crc_r[15:8]);
    fin.cur_x = cur_x;
    fin.cur_y = cur_y;
    fin.cur_z = cur_z;
    fin.got_x = coord_r[0];
    fin.got_y = coord_r[1];
    fin.got_z = coord_r[2];
  end

endmodule
`default_nettype wire

@@ design/mprc_near.sv @@
`default_nettype none
module mprc_near (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fin_valid,
  input  wire mprc_pkg::fin_t fin,
  input  wire mprc_pkg::tol_t tol,
  input  wire logic          out_ready,
  output logic               s1_ready,
  output logic               out_valid,
  output logic               crc_good,
  output logic               near
);
  import mprc_pkg::*;

  logic s1_v_r;
  fin_t s1_r;
  logic o_v_r, o_good_r, o_near_r;
  logic o_load;
  logic near_nxt;

  function automatic logic axis_near(input pos_t cur, input pos_t got, input tol_t t);
    logic signed [POS_W:0] d;
    logic [POS_W:0] mag;
    d   = {cur[POS_W-1], cur} - {got[POS_W-1], got};
    mag = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
    return mag < {{(POS_W+1-TOL_W){1'b0}}, t};
  endfunction

  assign o_load   = !o_v_r || out_ready;
  assign s1_ready = !s1_v_r || o_load;

  assign near_nxt = s1_r.good &&
                    axis_near(s1_r.cur_x, s1_r.got_x, tol) &&
                    axis_near(s1_r.cur_y, s1_r.got_y, tol) &&
                    axis_near(s1_r.cur_z, s1_r.got_z, tol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= fin_valid;
      end
      if (o_load) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && fin_valid) begin
      s1_r <= fin;
    end
    if (o_load && s1_v_r) begin
      o_good_r <= s1_r.good;
      o_near_r <= near_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign crc_good  = o_good_r;
  assign near      = o_near_r;

endmodule
`default_nettype wire

@@ design/mprc_checker.sv @@
`default_nettype none
`include "modbus_position_reply_checker_unit_defines.svh"
module mprc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic crc_good,
  input wire logic near
);

  `MPRC_ASSERT(a_near_needs_crc, out_valid |-> (!near || crc_good), "near without good crc")
  `MPRC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(crc_good) && $stable(near)), "stalled result changed")
  `MPRC_ASSERT(a_result_after_request, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without final byte")
  `MPRC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind modbus_position_reply_checker_unit mprc_checker u_mprc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .crc_good  (out_res.crc_good),
  .near      (out_res.near)
);
`default_nettype wire
